>>> rtl/core/bfba_pkg.sv
// Shared types and defaults for the best-fit block allocator.
// No dependencies; used by bfba_scan and best_fit_block_allocator.
`default_nettype none

package bfba_pkg;

	localparam int NUM_BLOCKS_DEF = 16;
	localparam int SIZE_WIDTH_DEF = 16;
	localparam int BLOCK_COUNT_W  = 5;
	localparam int ENTRY_W        = 4;
	localparam int SIZE_VALUE_W   = 16;
	localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                    granted;
		logic [ENTRY_W-1:0]      chosen_block;
		logic [SIZE_VALUE_W-1:0] leftover_size;
	} scan_res_t;

endpackage

`default_nettype wire

>>> rtl/core/bfba_mem.sv
// Free-size table: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module bfba_mem #(
	parameter int DEPTH  = 16,
	parameter int IDX_W  = 4,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [IDX_W-1:0]  waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [IDX_W-1:0]  raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/bfba_scan.sv
// Sequencer and shared subtract/compare unit for the best-fit search.
// Depends on bfba_pkg; drives the table in bfba_mem.
`default_nettype none

module bfba_scan #(
	parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_WIDTH = bfba_pkg::SIZE_WIDTH_DEF,
	parameter int IDX_W      = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [bfba_pkg::BLOCK_COUNT_W-1:0]  block_count,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                in_type,
	input  wire logic [bfba_pkg::ENTRY_W-1:0]        in_index,
	input  wire logic [bfba_pkg::SIZE_VALUE_W-1:0]   in_size,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output bfba_pkg::scan_res_t                      res,
	output logic                                     mem_we,
	output logic      [IDX_W-1:0]                    mem_waddr,
	output logic      [SIZE_WIDTH-1:0]               mem_wdata,
	output logic                                     mem_re,
	output logic      [IDX_W-1:0]                    mem_raddr,
	input  wire logic [SIZE_WIDTH-1:0]               mem_rdata
);

	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	bfba_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      limit_q;
	logic [CNT_W-1:0]      limit_d;
	logic [SIZE_WIDTH-1:0] size_q;
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [SIZE_WIDTH-1:0] best_left_q;
	logic                  cmp_vld_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;

	logic                  accept;
	logic                  load_hit;
	logic [SIZE_WIDTH-1:0] in_size_w;
	logic [SIZE_WIDTH-1:0] left;
	logic                  fits;
	logic                  better;
	logic                  scan_last;

	assign accept    = in_valid && in_ready;
	assign in_size_w = SIZE_WIDTH'(in_size);
	assign load_hit  = (32'(in_index) < NUM_BLOCKS);
	assign limit_d   = (32'(block_count) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
	                                                    : CNT_W'(block_count);
	assign scan_last = (cnt_q == limit_q - CNT_W'(1));

	// shared unit: one subtract and two compares per table entry
	assign fits   = mem_rdata > size_q;
	assign left   = mem_rdata - size_q;
	assign better = fits && (!found_q || (left < best_left_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfba_pkg::ST_IDLE: begin
				if (accept && in_type == bfba_pkg::REQ_ALLOC) begin
					state_d = (limit_d == '0) ? bfba_pkg::ST_FINISH : bfba_pkg::ST_SCAN;
				end
			end
			bfba_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = bfba_pkg::ST_DRAIN;
				end
			end
			bfba_pkg::ST_DRAIN: begin
				state_d = bfba_pkg::ST_FINISH;
			end
			bfba_pkg::ST_FINISH: begin
				if (res_ready) begin
					state_d = bfba_pkg::ST_IDLE;
				end
			end
			default: state_d = bfba_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = best_idx_q;
		mem_wdata = best_left_q;
		unique case (state_q)
			bfba_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_type == bfba_pkg::REQ_LOAD && load_hit) begin
					mem_we    = 1'b1;
					mem_waddr = IDX_W'(in_index);
					mem_wdata = in_size_w;
				end
			end
			bfba_pkg::ST_SCAN: begin
				mem_re = 1'b1;
			end
			bfba_pkg::ST_DRAIN: begin
			end
			bfba_pkg::ST_FINISH: begin
				res_valid = 1'b1;
				mem_we    = res_ready && found_q;
			end
			default: begin
			end
		endcase
	end

	assign mem_raddr = cnt_q[IDX_W-1:0];

	assign res.granted       = found_q;
	assign res.chosen_block  = found_q ? bfba_pkg::ENTRY_W'(best_idx_q) : '0;
	assign res.leftover_size = found_q ? bfba_pkg::SIZE_VALUE_W'(best_left_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bfba_pkg::ST_IDLE;
			cnt_q      <= '0;
			found_q    <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == bfba_pkg::ST_SCAN);
			if (accept) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (state_q == bfba_pkg::ST_SCAN) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (cmp_vld_s1 && better) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			size_q  <= in_size_w;
			limit_q <= limit_d;
		end
		if (state_q == bfba_pkg::ST_SCAN) begin
			cmp_idx_s1 <= cnt_q[IDX_W-1:0];
		end
		if (cmp_vld_s1 && better) begin
			best_idx_q  <= cmp_idx_s1;
			best_left_q <= left;
		end
	end

`ifndef SYNTHESIS
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (state_q == bfba_pkg::ST_SCAN || state_q == bfba_pkg::ST_DRAIN))
		else $error("compare stage active outside scan");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfba_pkg::ST_SCAN) |-> (cnt_q < limit_q))
		else $error("scan counter past block count");

	a_no_exact_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfba_pkg::ST_FINISH && found_q) |-> (best_left_q != '0))
		else $error("exact fit selected");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_type == bfba_pkg::REQ_ALLOC) |=> !in_ready)
		else $error("input taken during search");
`endif

endmodule

`default_nettype wire

>>> rtl/core/best_fit_block_allocator.sv
// Best-fit block allocator top level: config register, output register.
// Depends on bfba_pkg, bfba_mem and bfba_scan.
//
//  channel  | dir | beat fields (low bit first)
//  ---------+-----+-----------------------------------------------
//  s_ axis  | in  | tuser: req_type; tdata: entry_index, size_value
//  m_ axis  | out | tuser: granted;  tdata: chosen_block, leftover_size
//  cfg      | in  | cfg_wdata: block_count, written when cfg_wen
//
// A load beat leaves s_tready high for the next beat. An allocate beat holds
// s_tready low while the search reads min(block_count, NUM_BLOCKS) table entries,
// one entry per cycle through the single read port, and until its result is passed
// on. A zero count skips the search and holds s_tready low until the result is passed on.
// A finished result waits in the output register; a new beat is taken meanwhile.
// A second result waits in the sequencer, s_tready low, until m_tready frees it.
// Reset clears control state only; table entries are undefined until loaded.
`default_nettype none

module best_fit_block_allocator #(
	parameter int NUM_BLOCKS = bfba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_WIDTH = bfba_pkg::SIZE_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wen,
	input  wire logic [bfba_pkg::BLOCK_COUNT_W-1:0] cfg_wdata,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [23:0]                        s_tdata,  // entry_index, size_value
	input  wire logic                               s_tuser,  // req_type
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [23:0]                        m_tdata,  // chosen_block, leftover_size
	output logic                                    m_tuser   // granted
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	logic [bfba_pkg::BLOCK_COUNT_W-1:0] block_count_q;
	logic                               m_valid_q;
	bfba_pkg::scan_res_t                res_q;
	bfba_pkg::scan_res_t                res;
	logic                               res_valid;
	logic                               res_ready;
	logic                               mem_we;
	logic [IDX_W-1:0]                   mem_waddr;
	logic [SIZE_WIDTH-1:0]              mem_wdata;
	logic                               mem_re;
	logic [IDX_W-1:0]                   mem_raddr;
	logic [SIZE_WIDTH-1:0]              mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= bfba_pkg::BLOCK_COUNT_RST;
		end else if (cfg_wen) begin
			block_count_q <= cfg_wdata;
		end
	end

	bfba_mem #(
		.DEPTH  (NUM_BLOCKS),
		.IDX_W  (IDX_W),
		.DATA_W (SIZE_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bfba_scan #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_WIDTH (SIZE_WIDTH),
		.IDX_W      (IDX_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.block_count (block_count_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_type     (s_tuser),
		.in_index    (s_tdata[3:0]),
		.in_size     (s_tdata[19:4]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.granted;
	assign m_tdata  = {4'b0000, res_q.leftover_size, res_q.chosen_block};

endmodule

`default_nettype wire
